@@ rtl/mcep_pkg.sv @@
// ----------------------------------------------------------------------------
// mcep_pkg
// Shared types and codes for the multi-channel echo pulse capture block.
// ----------------------------------------------------------------------------
package mcep_pkg;

  // Action codes carried by an input item.
  typedef enum logic {
    ACT_ARM  = 1'b0,
    ACT_EDGE = 1'b1
  } mcep_action_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_MAX_ECHO_US    = 1'b0,
    REG_SENSORS_IN_USE = 1'b1
  } mcep_reg_t;

  localparam int unsigned      APB_ADDR_W        = 3;
  localparam int unsigned      APB_DATA_W        = 32;
  localparam logic [31:0]      MAX_ECHO_US_RESET = 32'd30000;
  localparam logic [3:0]       SENSORS_RESET     = 4'd8;

  // One input item.
  typedef struct packed {
    mcep_action_t action;
    logic [7:0]   sensor;
    logic         level_high;
    logic [31:0]  now_us;
    logic         receiver_full;
  } mcep_in_t;

  // One result item.
  typedef struct packed {
    logic        event_valid;
    logic        event_dropped;
    logic [2:0]  event_sensor;
    logic [31:0] echo_duration;
    logic        timed_out;
    logic [31:0] error_total;
    logic [31:0] drop_total;
    logic [31:0] sensor_drop_total;
  } mcep_out_t;

  // Configuration values handed from the register block to the datapath.
  typedef struct packed {
    logic [31:0] max_echo_us;
    logic [3:0]  sensors_in_use;
  } mcep_cfg_t;

endpackage

@@ rtl/mcep_stream_if.sv @@
// ----------------------------------------------------------------------------
// mcep_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface mcep_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mcep_apb_regs.sv @@
// ----------------------------------------------------------------------------
// mcep_apb_regs
// APB-style configuration registers: echo timeout limit and channel count.
// ----------------------------------------------------------------------------
module mcep_apb_regs
  import mcep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output mcep_cfg_t             cfg
);

  mcep_reg_t reg_sel;
  logic      wr_en;

  // Registers sit on 4-byte boundaries; address bit 2 picks the register.
  assign reg_sel = mcep_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_echo_us    <= MAX_ECHO_US_RESET;
      cfg.sensors_in_use <= SENSORS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_ECHO_US:    cfg.max_echo_us    <= pwdata;
        REG_SENSORS_IN_USE: cfg.sensors_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_sel)
      REG_MAX_ECHO_US:    prdata = cfg.max_echo_us;
      REG_SENSORS_IN_USE: prdata = {28'd0, cfg.sensors_in_use};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/multi_channel_echo_pulse_capture_core.sv @@
// An accepted item passes through the input register, then the result register,
// and is held longer while the result side stalls.
// Throughput: one item per cycle unless the result side stalls; channel state
// is updated as an item leaves the input register; the next item sees it.
// Reset (rst, synchronous): all channels disarmed, all counts zero, both
// pipeline stages empty, configuration back to 30000 us and 8 channels.
// ----------------------------------------------------------------------------
// multi_channel_echo_pulse_capture_core
// Measures echo pulse widths on several sensor channels and keeps error and
// drop statistics.
// ----------------------------------------------------------------------------
module multi_channel_echo_pulse_capture_core
  import mcep_pkg::*;
#(
  parameter int unsigned MAX_SENSORS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  mcep_stream_if.sink           cmd,
  mcep_stream_if.source         rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam logic [7:0]  MAX_S8 = 8'(MAX_SENSORS);

  mcep_cfg_t cfg;

  // Pipeline registers.
  logic      s1_valid;
  mcep_in_t  s1_item;
  logic      r_valid;
  mcep_out_t r_item;

  // Per-channel state.
  logic [MAX_SENSORS-1:0] armed;
  logic [MAX_SENSORS-1:0] high_seen;
  logic [MAX_SENSORS-1:0] drop_written;
  logic [31:0]            rise_mem [MAX_SENSORS];
  logic [31:0]            drop_mem [MAX_SENSORS];
  logic [31:0]            rd_rise;
  logic [31:0]            rd_drops;
  logic [31:0]            all_drops;
  logic [31:0]            bad_arm_count;

  // Datapath signals.
  logic             accept;
  logic             s1_adv;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] ch;
  logic [7:0]       limit;
  logic             ch_valid;
  logic             is_arm;
  logic             edge_ok;
  logic             rise_hit;
  logic             fall_hit;
  logic             drop_hit;
  logic [31:0]      width;
  logic             too_long;
  logic [31:0]      drops_cur;
  logic [31:0]      drops_new;
  logic             rise_wr_en;
  logic [31:0]      rise_wr_data;
  logic [31:0]      all_drops_next;
  logic [31:0]      bad_arm_count_next;
  mcep_out_t        res;

  mcep_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input stage moves on whenever the result register is free.
  assign s1_adv    = s1_valid && (!r_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;
  assign rsp.valid = r_valid;
  assign rsp.data  = r_item;

  assign in_idx = cmd.data.sensor[IDX_W-1:0];
  assign ch     = s1_item.sensor[IDX_W-1:0];

  // Channel range check against the active channel count, saturated.
  always_comb begin
    if ({4'd0, cfg.sensors_in_use} > MAX_S8) begin
      limit = MAX_S8;
    end else begin
      limit = {4'd0, cfg.sensors_in_use};
    end
  end
  assign ch_valid = s1_item.sensor < limit;

  // Item decode and pulse measurement.
  assign is_arm   = (s1_item.action == ACT_ARM);
  assign edge_ok  = !is_arm && ch_valid && armed[ch];
  assign rise_hit = edge_ok && s1_item.level_high;
  assign fall_hit = edge_ok && !s1_item.level_high && high_seen[ch];
  assign drop_hit = fall_hit && s1_item.receiver_full;
  assign width    = s1_item.now_us - rd_rise;
  assign too_long = (width == 32'd0) || (width > cfg.max_echo_us);

  // Counters.
  assign drops_cur          = drop_written[ch] ? rd_drops : 32'd0;
  assign drops_new          = drops_cur + 32'd1;
  assign all_drops_next     = all_drops + {31'd0, drop_hit};
  assign bad_arm_count_next = bad_arm_count + {31'd0, is_arm && !ch_valid};

  // Rise time memory write: cleared on arm, loaded on a rising edge.
  assign rise_wr_en   = s1_adv && ((is_arm && ch_valid) || rise_hit);
  assign rise_wr_data = is_arm ? 32'd0 : s1_item.now_us;

  // Result item.
  always_comb begin
    res                   = '0;
    res.event_valid       = fall_hit && !s1_item.receiver_full;
    res.event_dropped     = drop_hit;
    res.event_sensor      = fall_hit ? s1_item.sensor[2:0] : 3'd0;
    res.echo_duration     = (fall_hit && !too_long) ? width : 32'd0;
    res.timed_out         = fall_hit && too_long;
    res.error_total       = bad_arm_count_next;
    res.drop_total        = all_drops_next;
    res.sensor_drop_total = !ch_valid ? 32'd0 : (drop_hit ? drops_new : drops_cur);
  end

  // Control state and per-channel flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      r_valid       <= 1'b0;
      armed         <= '0;
      high_seen     <= '0;
      drop_written  <= '0;
      all_drops     <= '0;
      bad_arm_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        r_valid <= 1'b1;
      end else if (rsp.ready) begin
        r_valid <= 1'b0;
      end
      if (s1_adv) begin
        all_drops     <= all_drops_next;
        bad_arm_count <= bad_arm_count_next;
        if (is_arm && ch_valid) begin
          armed[ch]     <= 1'b1;
          high_seen[ch] <= 1'b0;
        end
        if (rise_hit) begin
          high_seen[ch] <= 1'b1;
        end
        if (fall_hit) begin
          armed[ch]     <= 1'b0;
          high_seen[ch] <= 1'b0;
        end
        if (drop_hit) begin
          drop_written[ch] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= cmd.data;
    end
    if (s1_adv) begin
      r_item <= res;
    end
  end

  // Rise time memory, read at accept with bypass of the write in flight.
  always_ff @(posedge clk) begin
    if (rise_wr_en) begin
      rise_mem[ch] <= rise_wr_data;
    end
    if (accept) begin
      if (rise_wr_en && (ch == in_idx)) begin
        rd_rise <= rise_wr_data;
      end else begin
        rd_rise <= rise_mem[in_idx];
      end
    end
  end

  // Per-channel drop count memory, same read scheme.
  always_ff @(posedge clk) begin
    if (s1_adv && drop_hit) begin
      drop_mem[ch] <= drops_new;
    end
    if (accept) begin
      if (s1_adv && drop_hit && (ch == in_idx)) begin
        rd_drops <= drops_new;
      end else begin
        rd_drops <= drop_mem[in_idx];
      end
    end
  end

`ifndef ASSERT_OFF
  // A produced event is either delivered or dropped, never both.
  a_deliver_or_drop: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.event_valid && rsp.data.event_dropped))
    else $error("event both delivered and dropped");

  // A timeout always reports a zero duration.
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.timed_out) |-> (rsp.data.echo_duration == 32'd0))
    else $error("timeout with nonzero duration");

  // A dropped event bumps the total drop count by one.
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && drop_hit) |=> (all_drops == $past(all_drops) + 32'd1))
    else $error("drop count did not advance");

  // A completed pulse leaves its channel disarmed.
  a_fall_disarms: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && fall_hit) |=> !armed[$past(ch)])
    else $error("channel still armed after echo");

  // The result register only fills from the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> $past(s1_valid))
    else $error("result appeared without an input item");
`endif

endmodule
